// File: rtl/mstk_pkg.sv
// Shared types, codes and defaults for the max-tracking stack.
`timescale 1ns / 1ps

package mstk_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int WIDTH_DEF   = 32;
    localparam int KIND_W      = 3;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;
    localparam int M_PAD_W     = M_TDATA_W - VALUE_W - STATUS_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH     = 3'd0,
        KIND_POP      = 3'd1,
        KIND_TOP      = 3'd2,
        KIND_PEEK_MAX = 3'd3,
        KIND_POP_MAX  = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TOP_RD,
        ST_SCAN,
        ST_MAX_DONE,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic push;
        logic res_empty;
        logic res_full;
        logic res_zero;
        logic top_read;
        logic top_take;
        logic scan_start;
        logic scan_step;
        logic max_take;
        logic shift_start;
        logic shift_step;
        logic occ_dec;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        kind_t kind;
        logic  full;
        logic  empty;
        logic  scan_more;
        logic  max_at_top;
        logic  out_busy;
    } stat_t;

endpackage

// File: rtl/mstk_ctrl.sv
// Controller state machine that sequences each stack operation.
`timescale 1ns / 1ps

module mstk_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  mstk_pkg::stat_t stat,
    output mstk_pkg::cmd_t  cmd
);
    import mstk_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (stat.kind)
                    KIND_POP, KIND_TOP: begin
                        state_next = stat.empty ? ST_EMIT : ST_TOP_RD;
                    end
                    KIND_PEEK_MAX, KIND_POP_MAX: begin
                        state_next = stat.empty ? ST_EMIT : ST_SCAN;
                    end
                    default: begin
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_TOP_RD: begin
                state_next = ST_EMIT;
            end
            ST_SCAN: begin
                if (!stat.scan_more) begin
                    state_next = ST_MAX_DONE;
                end
            end
            ST_MAX_DONE: begin
                if (stat.kind == KIND_POP_MAX && !stat.max_at_top) begin
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SHIFT: begin
                if (!stat.scan_more) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!stat.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_DECODE: begin
                case (stat.kind)
                    KIND_PUSH: begin
                        cmd.res_full = stat.full;
                        cmd.push     = !stat.full;
                    end
                    KIND_POP, KIND_TOP: begin
                        cmd.res_empty = stat.empty;
                        cmd.top_read  = !stat.empty;
                    end
                    KIND_PEEK_MAX, KIND_POP_MAX: begin
                        cmd.res_empty  = stat.empty;
                        cmd.scan_start = !stat.empty;
                    end
                    default: begin
                        cmd.res_zero = 1'b1;
                    end
                endcase
            end
            ST_TOP_RD: begin
                cmd.top_take = 1'b1;
                cmd.occ_dec  = (stat.kind == KIND_POP);
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            ST_MAX_DONE: begin
                cmd.max_take = 1'b1;
                if (stat.kind == KIND_POP_MAX) begin
                    cmd.occ_dec     = stat.max_at_top;
                    cmd.shift_start = !stat.max_at_top;
                end
            end
            ST_SHIFT: begin
                cmd.shift_step = 1'b1;
                cmd.occ_dec    = !stat.scan_more;
            end
            ST_EMIT: begin
                cmd.emit = !stat.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/mstk_dp.sv
// Datapath: entry memory, occupancy, max scan, compaction and result register.
`timescale 1ns / 1ps

module mstk_dp #(
    parameter int DEPTH = mstk_pkg::DEPTH_DEF,
    parameter int WIDTH = mstk_pkg::WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mstk_pkg::cmd_t                 cmd,
    output mstk_pkg::stat_t                stat,
    input  logic [mstk_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [mstk_pkg::KIND_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mstk_pkg::M_TDATA_W-1:0] m_tdata
);
    import mstk_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [WIDTH-1:0] wr_data;

    kind_t            kind_reg, kind_next;
    logic [WIDTH-1:0] word_reg, word_next;
    logic [OW-1:0]    occ_reg, occ_next;
    logic [OW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    wr_idx_reg, wr_idx_next;
    logic [WIDTH-1:0] best_reg, best_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [VALUE_W-1:0] res_val_reg, res_val_next;
    status_t          res_stat_reg, res_stat_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic signed [VALUE_W-1:0] push_s;
    logic [63:0]               push_ext;
    logic signed [WIDTH-1:0]   rd_s;
    logic signed [WIDTH-1:0]   best_s;
    logic [63:0]               rd_ext;
    logic [63:0]               best_ext;
    logic [OW-1:0]             occ_m1;
    logic [OW-1:0]             idx_m1;
    logic [OW-1:0]             pos_p1;
    logic                      scan_first;
    logic                      scan_better;
    logic                      scan_more;

    // Push values are sign-extended and cut to the stored word width.
    assign push_s   = signed'(s_tdata[VALUE_W-1:0]);
    assign push_ext = 64'(push_s);
    assign rd_s     = signed'(rdata_reg);
    assign best_s   = signed'(best_reg);
    assign rd_ext   = 64'(rd_s);
    assign best_ext = 64'(best_s);

    assign occ_m1      = occ_reg - OW'(1);
    assign idx_m1      = idx_reg - OW'(1);
    assign pos_p1      = OW'(pos_reg) + OW'(1);
    assign scan_first  = (idx_reg == OW'(1));
    assign scan_better = (rd_s >= best_s);
    assign scan_more   = (idx_reg < occ_reg);

    always_comb begin
        kind_next     = kind_reg;
        word_next     = word_reg;
        occ_next      = occ_reg;
        idx_next      = idx_reg;
        wr_idx_next   = wr_idx_reg;
        best_next     = best_reg;
        pos_next      = pos_reg;
        res_val_next  = res_val_reg;
        res_stat_next = res_stat_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[AW-1:0];
        wr_en         = 1'b0;
        wr_addr       = occ_reg[AW-1:0];
        wr_data       = word_reg;

        if (cmd.load) begin
            kind_next = kind_t'(s_tuser);
            word_next = push_ext[WIDTH-1:0];
        end
        if (cmd.push) begin
            wr_en         = 1'b1;
            occ_next      = occ_reg + OW'(1);
            res_val_next  = '0;
            res_stat_next = STAT_OK;
        end
        if (cmd.res_empty) begin
            res_val_next  = '0;
            res_stat_next = STAT_EMPTY;
        end
        if (cmd.res_full) begin
            res_val_next  = '0;
            res_stat_next = STAT_FULL;
        end
        if (cmd.res_zero) begin
            res_val_next  = '0;
            res_stat_next = STAT_OK;
        end
        if (cmd.top_read) begin
            rd_en   = 1'b1;
            rd_addr = occ_m1[AW-1:0];
        end
        if (cmd.top_take) begin
            res_val_next  = rd_ext[VALUE_W-1:0];
            res_stat_next = STAT_OK;
        end
        if (cmd.scan_start) begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            idx_next = OW'(1);
        end
        // The read data holds the entry at idx - 1; ties move toward the top.
        if (cmd.scan_step) begin
            if (scan_first || scan_better) begin
                best_next = rdata_reg;
                pos_next  = idx_m1[AW-1:0];
            end
            if (scan_more) begin
                rd_en    = 1'b1;
                idx_next = idx_reg + OW'(1);
            end
        end
        if (cmd.max_take) begin
            res_val_next  = best_ext[VALUE_W-1:0];
            res_stat_next = STAT_OK;
        end
        if (cmd.shift_start) begin
            rd_en       = 1'b1;
            rd_addr     = pos_p1[AW-1:0];
            wr_idx_next = pos_reg;
            idx_next    = pos_p1 + OW'(1);
        end
        // Each step writes the entry read in the previous cycle into the slot below it.
        if (cmd.shift_step) begin
            wr_en       = 1'b1;
            wr_addr     = wr_idx_reg;
            wr_data     = rdata_reg;
            wr_idx_next = wr_idx_reg + AW'(1);
            if (scan_more) begin
                rd_en    = 1'b1;
                idx_next = idx_reg + OW'(1);
            end
        end
        if (cmd.occ_dec) begin
            occ_next = occ_m1;
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{M_PAD_W{1'b0}}, res_stat_reg, res_val_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            occ_reg      <= occ_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        word_reg     <= word_next;
        idx_reg      <= idx_next;
        wr_idx_reg   <= wr_idx_next;
        best_reg     <= best_next;
        pos_reg      <= pos_next;
        res_val_reg  <= res_val_next;
        res_stat_reg <= res_stat_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign stat.kind       = kind_reg;
    assign stat.full       = (occ_reg == OW'(DEPTH));
    assign stat.empty      = (occ_reg == '0);
    assign stat.scan_more  = scan_more;
    assign stat.max_at_top = (pos_p1 == occ_reg);
    assign stat.out_busy   = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OW'(DEPTH))
        else $error("occupancy beyond depth");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (occ_reg != OW'(DEPTH)))
        else $error("push written into a full stack");

    a_shift_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift_step |-> ((OW'(wr_idx_reg) + OW'(1)) < occ_reg))
        else $error("compaction write outside held entries");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (m_tvalid_reg && (m_tdata_reg[VALUE_W +: STATUS_W] ==
                                       $past(res_stat_reg))))
        else $error("result not loaded into the output register");

endmodule

// File: rtl/max_stack.sv
// Top level of the bounded stack of signed words with maximum tracking.
//
// Input channel (s_): each transfer carries one operation in s_tuser
// (push, pop, top, peek max, pop max) and the value to push in s_tdata.
// Result channel (m_): exactly one transfer per input item, carrying the
// popped or read value and a status (ok, stack empty, stack full).
// Items are handled one at a time by a controller that steps the datapath.
// Peek max and pop max scan all held entries for the maximum; pop max then
// compacts the entries above the removed maximum unless it was the top one.
// The scan and the compaction each move one entry per cycle through the
// single read port of the entry memory.
// The next item is taken in the cycle after a result is loaded, while that
// result may still wait in the output register. If the receiver stalls, the
// block finishes the current item and holds it until the output frees up.
// Reset empties the stack and drops any pending result; entry contents are
// left as they are and are never read before being written again.
`timescale 1ns / 1ps

module max_stack #(
    parameter int DEPTH = mstk_pkg::DEPTH_DEF,
    parameter int WIDTH = mstk_pkg::WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mstk_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] push_value
    input  logic [mstk_pkg::KIND_W-1:0]    s_tuser,   // [2:0] kind
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mstk_pkg::M_TDATA_W-1:0] m_tdata    // [31:0] result_value, [33:32] status
);
    import mstk_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    mstk_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mstk_dp #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
